// ===== src/fkvs_pkg.sv =====
// Shared types, codes and helpers of the flash key-value store.
package fkvs_pkg;

  localparam logic [15:0] KEY_FREE        = 16'hFFFF;
  localparam logic [15:0] KEY_DELETED     = 16'h0000;
  localparam logic [31:0] AREA_MAGIC      = 32'h37427411;
  localparam logic [15:0] HDR_BYTES       = 16'd4;
  localparam logic [7:0]  BYTE_ERASED     = 8'hFF;
  localparam int          MAX_VALUE_BYTES = 255;

  typedef enum logic [2:0] {
    KIND_PUT_BEGIN     = 3'd0,
    KIND_PUT_DATA      = 3'd1,
    KIND_GET           = 3'd2,
    KIND_DELETE        = 3'd3,
    KIND_ENUM_RESTART  = 3'd4,
    KIND_ENUM_NEXT     = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNCHANGED   = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_NO_SPACE    = 3'd3,
    ST_END_OF_LIST = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] found_key;
    logic [7:0]  stored_length;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_result;
  } res_t;

  // Header plus value padded to whole words.
  function automatic logic [15:0] rec_size(input logic [7:0] len);
    return ((16'(len) + 16'd3) & 16'hFFFC) + HDR_BYTES;
  endfunction

  function automatic res_t mk_res(input status_e st, input logic [15:0] fkey,
                                  input logic [7:0] slen, input logic [31:0] word,
                                  input logic [2:0] cnt, input logic last);
    res_t r;
    r.status        = st;
    r.found_key     = fkey;
    r.stored_length = slen;
    r.data_word     = word;
    r.byte_count    = cnt;
    r.last_result   = last;
    return r;
  endfunction

  function automatic logic key_reserved(input logic [15:0] key);
    return (key == KEY_DELETED) || (key == KEY_FREE);
  endfunction

endpackage

// ===== src/flash_key_value_store_top.sv =====
// Log-structured key-value store over two byte-wide flash-like banks.
//
//  channel | dir | handshake             | payload
//  s_axis  | in  | s_axis_tvalid/tready  | tdata: key, value_length, max_length, value_word
//          |     |                       | tuser: kind
//  m_axis  | out | m_axis_tvalid/tready  | tdata: status, found_key, stored_length,
//          |     |                       |        data_word, byte_count; tlast: last_result
//
// All work goes through one bank memory with a byte read port and a byte write port.
// A header walk reads the key low, key high and length bytes of each record; get reads
// the value bytes one by one, a put compare reads them and a program reads and writes them.
// Compaction erases the target bank, writes its magic and copies each live record.
// After reset a clearing pass loads the banks; no transaction is taken meanwhile.
// Results wait in an output register.
module flash_key_value_store_top #(
  parameter int BANK_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key[15:0], value_length[23:16], max_length[31:24],
                                     // value_word[63:32]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // status[2:0], found_key[18:3], stored_length[26:19],
                                     // data_word[58:27], byte_count[61:59], zero[63:62]
  output logic        m_axis_tlast   // last_result
);

  localparam int          MW         = $clog2(2 * BANK_BYTES);
  localparam logic [15:0] BANK_END   = 16'(BANK_BYTES);
  localparam logic [15:0] LIMIT      = 16'(BANK_BYTES - 4);
  localparam logic [15:0] ERASE_LAST = 16'(BANK_BYTES - 1);
  localparam logic [MW-1:0] CLR_LAST = MW'(2 * BANK_BYTES - 1);

  typedef enum logic [21:0] {
    S_INIT   = 22'd1 << 0,
    S_IDLE   = 22'd1 << 1,
    S_DISP   = 22'd1 << 2,
    S_W0     = 22'd1 << 3,
    S_W1     = 22'd1 << 4,
    S_W2     = 22'd1 << 5,
    S_W3     = 22'd1 << 6,
    S_RET    = 22'd1 << 7,
    S_EMIT   = 22'd1 << 8,
    S_G_RD   = 22'd1 << 9,
    S_G_CAP  = 22'd1 << 10,
    S_C_RD   = 22'd1 << 11,
    S_C_CHK  = 22'd1 << 12,
    S_DEL0   = 22'd1 << 13,
    S_DEL1   = 22'd1 << 14,
    S_ER     = 22'd1 << 15,
    S_MAG    = 22'd1 << 16,
    S_CP_RD  = 22'd1 << 17,
    S_CP_WR  = 22'd1 << 18,
    S_SRCMAG = 22'd1 << 19,
    S_PW_RD  = 22'd1 << 20,
    S_PW_WR  = 22'd1 << 21
  } state_e;

  typedef enum logic [2:0] {
    CALL_GET, CALL_DEL, CALL_PFIND, CALL_PFREE, CALL_PFREE2, CALL_CSRC, CALL_ENUM
  } call_e;

  state_e          state_q, state_d;
  call_e           caller_q, caller_d;
  fkvs_pkg::kind_e kind_q, kind_d;
  logic [15:0] key_q, key_d;
  logic [7:0]  vlen_q, vlen_d, maxlen_q, maxlen_d;
  logic [31:0] in_word_q, in_word_d;
  logic        active_q, active_d;
  logic [15:0] pkey_q, pkey_d;
  logic [7:0]  plen_q, plen_d, pcount_q, pcount_d;
  logic [15:0] cursor_q, cursor_d;
  logic [15:0] off_q, off_d, doff_q, doff_d, cnt_q, cnt_d;
  logic [7:0]  lo_q, lo_d, hi_q, hi_d, wlen_q, wlen_d, n_q, n_d;
  logic        hit_q, hit_d;
  logic [31:0] gword_q, gword_d;
  fkvs_pkg::res_t res_q, res_d, out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic [MW-1:0] clr_q, clr_d;

  // bank memory
  logic [7:0]    mem [2 * BANK_BYTES];
  logic [7:0]    mem_rdata_q;
  logic          oob_q;
  logic          rd_bank, wr_bank, mem_we_req, mem_we;
  logic [15:0]   rd_off, wr_off;
  logic [7:0]    wr_data;
  logic [MW-1:0] rd_addr, wr_addr;
  logic [7:0]    rdval;

  // value buffer
  logic        pb_we;
  logic [7:0]  pb_raddr;
  logic [7:0]  pbyte;

  logic        can_emit;
  logic [15:0] wkey;

  function automatic logic [MW-1:0] baddr(input logic bank, input logic [15:0] off);
    return bank ? (MW'(off) + MW'(BANK_BYTES)) : MW'(off);
  endfunction

  fkvs_value_buf u_value_buf (
    .clk_i     (clk_i),
    .wr_en_i   (pb_we),
    .wr_addr_i (pcount_q[7:2]),
    .wr_data_i (in_word_q),
    .rd_addr_i (pb_raddr),
    .rd_byte_o (pbyte)
  );

  assign rdval    = oob_q ? fkvs_pkg::BYTE_ERASED : mem_rdata_q;
  assign can_emit = !out_valid_q || m_axis_tready;
  assign wkey     = {hi_q, lo_q};
  assign rd_addr  = baddr(rd_bank, rd_off);
  assign wr_addr  = (state_q == S_INIT) ? clr_q : baddr(wr_bank, wr_off);
  assign mem_we   = mem_we_req && ((state_q == S_INIT) || (wr_off < BANK_END));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rdata_q <= mem[rd_addr];
    oob_q       <= (rd_off >= BANK_END);
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last_result;
  assign m_axis_tdata  = {2'b00, out_q.byte_count, out_q.data_word, out_q.stored_length,
                          out_q.found_key, out_q.status};

  always_comb begin
    logic [15:0] put_key;
    logic [8:0]  sum9;
    logic [7:0]  newcnt;
    logic [31:0] gw;
    logic [15:0] target;
    logic [16:0] need;
    logic [15:0] hidx;
    logic [7:0]  pval;

    state_d     = state_q;
    caller_d    = caller_q;
    kind_d      = kind_q;
    key_d       = key_q;
    vlen_d      = vlen_q;
    maxlen_d    = maxlen_q;
    in_word_d   = in_word_q;
    active_d    = active_q;
    pkey_d      = pkey_q;
    plen_d      = plen_q;
    pcount_d    = pcount_q;
    cursor_d    = cursor_q;
    off_d       = off_q;
    doff_d      = doff_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    wlen_d      = wlen_q;
    n_d         = n_q;
    hit_d       = hit_q;
    gword_d     = gword_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    clr_d       = clr_q;

    rd_bank    = active_q;
    rd_off     = off_q;
    wr_bank    = active_q;
    wr_off     = off_q;
    wr_data    = 8'h00;
    mem_we_req = 1'b0;
    pb_we      = 1'b0;
    pb_raddr   = cnt_q[7:0];

    put_key = (kind_q == fkvs_pkg::KIND_PUT_BEGIN) ? key_q : pkey_q;
    sum9    = {1'b0, pcount_q} + 9'd4;
    newcnt  = (sum9 >= {1'b0, plen_q}) ? plen_q : sum9[7:0];
    gw      = (cnt_q[1:0] == 2'd0) ? 32'd0 : gword_q;
    gw[8*cnt_q[1:0] +: 8] = rdval;
    target  = (caller_q == CALL_PFIND) ? pkey_q : key_q;
    need    = {1'b0, off_q} + {1'b0, fkvs_pkg::rec_size(plen_q)} + 17'd4;
    hidx    = cnt_q - {8'd0, plen_q};
    pval    = (cnt_q < {8'd0, plen_q}) ? pbyte :
              (hidx == 16'd0) ? pkey_q[7:0] :
              (hidx == 16'd1) ? pkey_q[15:8] : plen_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        mem_we_req = 1'b1;
        wr_data = (clr_q < MW'(4)) ? fkvs_pkg::AREA_MAGIC[8*clr_q[1:0] +: 8]
                                   : fkvs_pkg::BYTE_ERASED;
        clr_d = clr_q + MW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d    = fkvs_pkg::kind_e'(s_axis_tuser);
          key_d     = s_axis_tdata[15:0];
          vlen_d    = s_axis_tdata[23:16];
          maxlen_d  = s_axis_tdata[31:24];
          in_word_d = s_axis_tdata[63:32];
          state_d   = S_DISP;
        end
      end

      S_DISP: begin
        state_d = S_IDLE;
        case (kind_q) inside
          fkvs_pkg::KIND_PUT_BEGIN: begin
            pcount_d = 8'd0;
            if ({1'b0, vlen_q} > 9'(fkvs_pkg::MAX_VALUE_BYTES)) begin
              plen_d  = 8'd0;
              res_d   = fkvs_pkg::mk_res(fkvs_pkg::ST_NO_SPACE, 16'd0, 8'd0, 32'd0, 3'd0, 1'b1);
              state_d = S_EMIT;
            end else begin
              pkey_d = key_q;
              plen_d = vlen_q;
              if (vlen_q == 8'd0) begin
                if (fkvs_pkg::key_reserved(put_key)) begin
                  res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_NOT_FOUND, 16'd0, 8'd0, 32'd0,
                                           3'd0, 1'b1);
                  state_d = S_EMIT;
                end else begin
                  off_d    = fkvs_pkg::HDR_BYTES;
                  caller_d = CALL_PFIND;
                  state_d  = S_W0;
                end
              end
            end
          end
          fkvs_pkg::KIND_PUT_DATA: begin
            if (pcount_q < plen_q) begin
              pb_we    = 1'b1;
              pcount_d = newcnt;
              if (newcnt == plen_q) begin
                if (fkvs_pkg::key_reserved(put_key)) begin
                  res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_NOT_FOUND, 16'd0, 8'd0, 32'd0,
                                           3'd0, 1'b1);
                  state_d = S_EMIT;
                end else begin
                  off_d    = fkvs_pkg::HDR_BYTES;
                  caller_d = CALL_PFIND;
                  state_d  = S_W0;
                end
              end
            end
          end
          fkvs_pkg::KIND_GET, fkvs_pkg::KIND_DELETE: begin
            if (fkvs_pkg::key_reserved(key_q)) begin
              res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_NOT_FOUND, 16'd0, 8'd0, 32'd0, 3'd0, 1'b1);
              state_d = S_EMIT;
            end else begin
              off_d    = fkvs_pkg::HDR_BYTES;
              caller_d = (kind_q == fkvs_pkg::KIND_GET) ? CALL_GET : CALL_DEL;
              state_d  = S_W0;
            end
          end
          fkvs_pkg::KIND_ENUM_RESTART: begin
            cursor_d = fkvs_pkg::HDR_BYTES;
            res_d    = fkvs_pkg::mk_res(fkvs_pkg::ST_OK, 16'd0, 8'd0, 32'd0, 3'd0, 1'b1);
            state_d  = S_EMIT;
          end
          fkvs_pkg::KIND_ENUM_NEXT: begin
            off_d    = cursor_q;
            caller_d = CALL_ENUM;
            state_d  = S_W0;
          end
          default: state_d = S_IDLE;
        endcase
      end

      // header walk: key low, key high, length
      S_W0: begin
        if (off_q >= LIMIT) begin
          hit_d   = 1'b0;
          state_d = S_RET;
        end else begin
          state_d = S_W1;
        end
      end
      S_W1: begin
        rd_off  = off_q + 16'd1;
        lo_d    = rdval;
        state_d = S_W2;
      end
      S_W2: begin
        rd_off  = off_q + 16'd2;
        hi_d    = rdval;
        state_d = S_W3;
      end
      S_W3: begin
        wlen_d  = rdval;
        state_d = S_RET;
        case (caller_q) inside
          CALL_GET, CALL_DEL, CALL_PFIND: begin
            if (wkey == fkvs_pkg::KEY_FREE) begin
              hit_d = 1'b0;
            end else if (wkey == target) begin
              hit_d = 1'b1;
            end else begin
              off_d   = off_q + fkvs_pkg::rec_size(rdval);
              state_d = S_W0;
            end
          end
          CALL_PFREE, CALL_PFREE2: begin
            if (wkey == fkvs_pkg::KEY_FREE) begin
              hit_d = 1'b1;
            end else begin
              off_d   = off_q + fkvs_pkg::rec_size(rdval);
              state_d = S_W0;
            end
          end
          CALL_ENUM: begin
            if (wkey == fkvs_pkg::KEY_DELETED) begin
              off_d   = off_q + fkvs_pkg::rec_size(rdval);
              state_d = S_W0;
            end else begin
              hit_d = 1'b1;
            end
          end
          default: hit_d = (wkey != fkvs_pkg::KEY_FREE);
        endcase
      end

      S_RET: begin
        case (caller_q) inside
          CALL_GET: begin
            if (!hit_q) begin
              res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_NOT_FOUND, 16'd0, 8'd0, 32'd0, 3'd0, 1'b1);
              state_d = S_EMIT;
            end else begin
              n_d = (wlen_q < maxlen_q) ? wlen_q : maxlen_q;
              if (wlen_q == 8'd0 || maxlen_q == 8'd0) begin
                res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_OK, 16'd0, wlen_q, 32'd0, 3'd0, 1'b1);
                state_d = S_EMIT;
              end else begin
                cnt_d   = 16'd0;
                state_d = S_G_RD;
              end
            end
          end
          CALL_DEL: begin
            if (!hit_q) begin
              res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_NOT_FOUND, 16'd0, 8'd0, 32'd0, 3'd0, 1'b1);
              state_d = S_EMIT;
            end else begin
              state_d = S_DEL0;
            end
          end
          CALL_PFIND: begin
            cnt_d = 16'd0;
            if (hit_q && wlen_q == plen_q) begin
              state_d = S_C_RD;
            end else if (hit_q) begin
              state_d = S_DEL0;
            end else begin
              off_d    = fkvs_pkg::HDR_BYTES;
              caller_d = CALL_PFREE;
              state_d  = S_W0;
            end
          end
          CALL_PFREE, CALL_PFREE2: begin
            cnt_d = 16'd0;
            if (hit_q && need < {1'b0, BANK_END}) begin
              state_d = S_PW_RD;
            end else if (caller_q == CALL_PFREE) begin
              state_d = S_ER;
            end else begin
              res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_NO_SPACE, 16'd0, 8'd0, 32'd0, 3'd0, 1'b1);
              state_d = S_EMIT;
            end
          end
          CALL_CSRC: begin
            cnt_d = 16'd0;
            if (!hit_q) begin
              state_d = S_SRCMAG;
            end else if (wkey == fkvs_pkg::KEY_DELETED) begin
              off_d   = off_q + fkvs_pkg::rec_size(wlen_q);
              state_d = S_W0;
            end else begin
              state_d = S_CP_RD;
            end
          end
          default: begin
            state_d = S_EMIT;
            if (hit_q && wkey != fkvs_pkg::KEY_FREE) begin
              cursor_d = off_q + fkvs_pkg::rec_size(wlen_q);
              res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_OK, wkey, 8'd0, 32'd0, 3'd0, 1'b1);
            end else begin
              cursor_d = off_q;
              res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_END_OF_LIST, 16'd0, 8'd0, 32'd0,
                                       3'd0, 1'b1);
            end
          end
        endcase
      end

      S_EMIT: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = res_q.last_result ? S_IDLE : S_G_RD;
        end
      end

      S_G_RD: begin
        rd_off  = off_q + fkvs_pkg::HDR_BYTES + cnt_q;
        state_d = S_G_CAP;
      end
      S_G_CAP: begin
        gword_d = gw;
        cnt_d   = cnt_q + 16'd1;
        if ((cnt_q + 16'd1) == {8'd0, n_q} || cnt_q[1:0] == 2'd3) begin
          res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_OK, 16'd0, wlen_q, gw,
                                   {1'b0, cnt_q[1:0]} + 3'd1,
                                   (cnt_q + 16'd1) == {8'd0, n_q});
          state_d = S_EMIT;
        end else begin
          state_d = S_G_RD;
        end
      end

      // compare stored value against the pending one
      S_C_RD: begin
        rd_off = off_q + fkvs_pkg::HDR_BYTES + cnt_q;
        if (cnt_q == {8'd0, plen_q}) begin
          res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_UNCHANGED, 16'd0, 8'd0, 32'd0, 3'd0, 1'b1);
          state_d = S_EMIT;
        end else begin
          state_d = S_C_CHK;
        end
      end
      S_C_CHK: begin
        if (rdval != pbyte) begin
          state_d = S_DEL0;
        end else begin
          cnt_d   = cnt_q + 16'd1;
          state_d = S_C_RD;
        end
      end

      // tombstone: clear both key bytes
      S_DEL0: begin
        mem_we_req = 1'b1;
        state_d    = S_DEL1;
      end
      S_DEL1: begin
        mem_we_req = 1'b1;
        wr_off     = off_q + 16'd1;
        if (kind_q == fkvs_pkg::KIND_DELETE) begin
          res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_OK, 16'd0, 8'd0, 32'd0, 3'd0, 1'b1);
          state_d = S_EMIT;
        end else begin
          off_d    = fkvs_pkg::HDR_BYTES;
          caller_d = CALL_PFREE;
          state_d  = S_W0;
        end
      end

      // compaction: erase target, magic, copy live records, retire source
      S_ER: begin
        mem_we_req = 1'b1;
        wr_bank    = !active_q;
        wr_off     = cnt_q;
        wr_data    = fkvs_pkg::BYTE_ERASED;
        cnt_d      = cnt_q + 16'd1;
        if (cnt_q == ERASE_LAST) begin
          cnt_d   = 16'd0;
          state_d = S_MAG;
        end
      end
      S_MAG: begin
        mem_we_req = 1'b1;
        wr_bank    = !active_q;
        wr_off     = cnt_q;
        wr_data    = fkvs_pkg::AREA_MAGIC[8*cnt_q[1:0] +: 8];
        cnt_d      = cnt_q + 16'd1;
        if (cnt_q == 16'd3) begin
          doff_d   = fkvs_pkg::HDR_BYTES;
          off_d    = fkvs_pkg::HDR_BYTES;
          caller_d = CALL_CSRC;
          state_d  = S_W0;
        end
      end
      S_CP_RD: begin
        rd_off = off_q + cnt_q;
        if (cnt_q == fkvs_pkg::rec_size(wlen_q)) begin
          doff_d  = doff_q + fkvs_pkg::rec_size(wlen_q);
          off_d   = off_q + fkvs_pkg::rec_size(wlen_q);
          state_d = S_W0;
        end else begin
          state_d = S_CP_WR;
        end
      end
      S_CP_WR: begin
        mem_we_req = 1'b1;
        wr_bank    = !active_q;
        wr_off     = doff_q + cnt_q;
        wr_data    = rdval;
        cnt_d      = cnt_q + 16'd1;
        state_d    = S_CP_RD;
      end
      S_SRCMAG: begin
        mem_we_req = 1'b1;
        wr_off     = cnt_q;
        cnt_d      = cnt_q + 16'd1;
        if (cnt_q == 16'd3) begin
          active_d = !active_q;
          off_d    = fkvs_pkg::HDR_BYTES;
          caller_d = CALL_PFREE2;
          state_d  = S_W0;
        end
      end

      // program value bytes, then key low, key high, length
      S_PW_RD: begin
        rd_off = (cnt_q < {8'd0, plen_q}) ? (off_q + fkvs_pkg::HDR_BYTES + cnt_q)
                                          : (off_q + hidx);
        if (cnt_q == ({8'd0, plen_q} + 16'd3)) begin
          res_d = fkvs_pkg::mk_res(fkvs_pkg::ST_OK, 16'd0, 8'd0, 32'd0, 3'd0, 1'b1);
          state_d = S_EMIT;
        end else begin
          state_d = S_PW_WR;
        end
      end
      S_PW_WR: begin
        mem_we_req = 1'b1;
        wr_off  = (cnt_q < {8'd0, plen_q}) ? (off_q + fkvs_pkg::HDR_BYTES + cnt_q)
                                           : (off_q + hidx);
        wr_data = rdval & pval;
        cnt_d   = cnt_q + 16'd1;
        state_d = S_PW_RD;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      caller_q    <= CALL_GET;
      kind_q      <= fkvs_pkg::KIND_PUT_BEGIN;
      active_q    <= 1'b0;
      pkey_q      <= 16'd0;
      plen_q      <= 8'd0;
      pcount_q    <= 8'd0;
      cursor_q    <= fkvs_pkg::HDR_BYTES;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      caller_q    <= caller_d;
      kind_q      <= kind_d;
      active_q    <= active_d;
      pkey_q      <= pkey_d;
      plen_q      <= plen_d;
      pcount_q    <= pcount_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    vlen_q    <= vlen_d;
    maxlen_q  <= maxlen_d;
    in_word_q <= in_word_d;
    off_q     <= off_d;
    doff_q    <= doff_d;
    cnt_q     <= cnt_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    wlen_q    <= wlen_d;
    n_q       <= n_d;
    gword_q   <= gword_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  a_pcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcount_q <= plen_q)
    else $error("pending count passed pending length");

  a_walk_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_W0 || state_q == S_W1 || state_q == S_W2 || state_q == S_W3) |-> !mem_we)
    else $error("bank written during header walk");

  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SRCMAG) |=> $stable(active_q))
    else $error("active bank changed outside compaction");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && can_emit) |=> m_axis_tvalid)
    else $error("result lost at output register");

endmodule

// ===== src/fkvs_value_buf.sv =====
// Word-wide buffer of the value bytes of a pending put, read one byte at a time.
module fkvs_value_buf (
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_addr_i,
  input  logic [31:0] wr_data_i,
  input  logic [7:0]  rd_addr_i,
  output logic [7:0]  rd_byte_o
);

  logic [31:0] mem_q [64];
  logic [31:0] rd_word_q;
  logic [1:0]  rd_sel_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_word_q <= mem_q[rd_addr_i[7:2]];
    rd_sel_q  <= rd_addr_i[1:0];
  end

  assign rd_byte_o = rd_word_q[8*rd_sel_q +: 8];

endmodule

// ===== tb/flash_key_value_store_checker.sv =====
// Checker for the flash key-value store: predicts results from input transactions and compares.
module flash_key_value_store_checker #(
  parameter int BANK_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          results_due_o
);

  localparam int WALK_END = BANK_BYTES - 4;

  logic [7:0]     flash_mem [2*BANK_BYTES];
  logic           live_bank;
  logic [15:0]    put_key;
  logic [7:0]     put_len;
  logic [8:0]     put_cnt;
  logic [7:0]     put_bytes [256];
  logic [15:0]    walk_pos;
  fkvs_pkg::res_t results_due [$];

  function automatic logic [7:0] flash_rd(input logic bank, input int off);
    if (off >= BANK_BYTES) return fkvs_pkg::BYTE_ERASED;
    return flash_mem[int'(bank) * BANK_BYTES + off];
  endfunction

  // Programming only clears bits.
  function automatic void flash_prog(input logic bank, input int off, input logic [7:0] v);
    if (off < BANK_BYTES) flash_mem[int'(bank) * BANK_BYTES + off] &= v;
  endfunction

  function automatic void write_magic(input logic bank);
    for (int i = 0; i < 4; i++) flash_prog(bank, i, fkvs_pkg::AREA_MAGIC[8*i +: 8]);
  endfunction

  function automatic logic [15:0] key_at(input logic bank, input int off);
    return {flash_rd(bank, off + 1), flash_rd(bank, off)};
  endfunction

  function automatic int record_bytes(input logic [7:0] len);
    return ((int'(len) + 3) & ~3) + 4;
  endfunction

  function automatic int locate_key(input logic [15:0] key);
    int off;
    off = 4;
    while (off < WALK_END && key_at(live_bank, off) != fkvs_pkg::KEY_FREE) begin
      if (key_at(live_bank, off) == key) return off;
      off += record_bytes(flash_rd(live_bank, off + 2));
    end
    return -1;
  endfunction

  function automatic int locate_free();
    int off;
    off = 4;
    while (off < WALK_END) begin
      if (key_at(live_bank, off) == fkvs_pkg::KEY_FREE) return off;
      off += record_bytes(flash_rd(live_bank, off + 2));
    end
    return -1;
  endfunction

  function automatic bit fits(input int off, input logic [7:0] len);
    return off >= 0 && off + record_bytes(len) + 4 < BANK_BYTES;
  endfunction

  function automatic void compact_banks();
    logic src, dst;
    bit   clean;
    int   off, doff, n;
    src   = live_bank;
    dst   = ~live_bank;
    clean = 1'b1;
    for (int i = 0; i < BANK_BYTES; i++)
      if (flash_rd(dst, i) != fkvs_pkg::BYTE_ERASED) clean = 1'b0;
    if (!clean)
      for (int i = 0; i < BANK_BYTES; i++)
        flash_mem[int'(dst) * BANK_BYTES + i] = fkvs_pkg::BYTE_ERASED;
    write_magic(dst);
    doff = 4;
    off  = 4;
    while (off < WALK_END && key_at(src, off) != fkvs_pkg::KEY_FREE) begin
      n = record_bytes(flash_rd(src, off + 2));
      if (key_at(src, off) != fkvs_pkg::KEY_DELETED) begin
        for (int i = 0; i < n; i++) flash_prog(dst, doff + i, flash_rd(src, off + i));
        doff += n;
      end
      off += n;
    end
    for (int i = 0; i < 4; i++) flash_prog(src, i, 8'h00);
    live_bank = dst;
  endfunction

  function automatic bit tombstone(input logic [15:0] key);
    int off;
    off = locate_key(key);
    if (off < 0) return 1'b0;
    flash_prog(live_bank, off, 8'h00);
    flash_prog(live_bank, off + 1, 8'h00);
    return 1'b1;
  endfunction

  function automatic fkvs_pkg::status_e store_put();
    int off, i;
    bit dummy;
    if (fkvs_pkg::key_reserved(put_key)) return fkvs_pkg::ST_NOT_FOUND;
    off = locate_key(put_key);
    if (off >= 0 && flash_rd(live_bank, off + 2) == put_len) begin
      for (i = 0; i < int'(put_len); i++)
        if (flash_rd(live_bank, off + 4 + i) != put_bytes[i]) break;
      if (i == int'(put_len)) return fkvs_pkg::ST_UNCHANGED;
    end
    dummy = tombstone(put_key);
    off = locate_free();
    if (!fits(off, put_len)) begin
      compact_banks();
      off = locate_free();
      if (!fits(off, put_len)) return fkvs_pkg::ST_NO_SPACE;
    end
    for (i = 0; i < int'(put_len); i++) flash_prog(live_bank, off + 4 + i, put_bytes[i]);
    flash_prog(live_bank, off, put_key[7:0]);
    flash_prog(live_bank, off + 1, put_key[15:8]);
    flash_prog(live_bank, off + 2, put_len);
    flash_prog(live_bank, off + 3, fkvs_pkg::BYTE_ERASED);
    return fkvs_pkg::ST_OK;
  endfunction

  function automatic void push_status(input fkvs_pkg::status_e st, input logic [15:0] fkey);
    results_due.push_back(fkvs_pkg::mk_res(st, fkey, 8'd0, 32'd0, 3'd0, 1'b1));
  endfunction

  function automatic void apply_request(input logic [2:0] kind, input logic [63:0] d);
    logic [15:0] key;
    logic [7:0]  vlen, mlen, slen;
    logic [31:0] word, w;
    int          off, n, c;
    key  = d[15:0];
    vlen = d[23:16];
    mlen = d[31:24];
    word = d[63:32];
    case (kind)
      fkvs_pkg::KIND_PUT_BEGIN: begin
        put_cnt = 0;
        put_key = key;
        put_len = vlen;
        if (vlen == 8'd0) push_status(store_put(), 16'd0);
      end
      fkvs_pkg::KIND_PUT_DATA: begin
        if (put_cnt < put_len) begin
          for (int i = 0; i < 4 && put_cnt < put_len; i++) begin
            put_bytes[put_cnt] = word[8*i +: 8];
            put_cnt++;
          end
          if (put_cnt >= put_len) push_status(store_put(), 16'd0);
        end
      end
      fkvs_pkg::KIND_GET: begin
        off = fkvs_pkg::key_reserved(key) ? -1 : locate_key(key);
        if (off < 0) push_status(fkvs_pkg::ST_NOT_FOUND, 16'd0);
        else begin
          slen = flash_rd(live_bank, off + 2);
          n    = (slen < mlen) ? int'(slen) : int'(mlen);
          if (n == 0)
            results_due.push_back(fkvs_pkg::mk_res(fkvs_pkg::ST_OK, 16'd0, slen, 32'd0,
                                                   3'd0, 1'b1));
          for (int pos = 0; pos < n; pos += 4) begin
            w = '0;
            c = (n - pos < 4) ? n - pos : 4;
            for (int i = 0; i < c; i++) w[8*i +: 8] = flash_rd(live_bank, off + 4 + pos + i);
            results_due.push_back(fkvs_pkg::mk_res(fkvs_pkg::ST_OK, 16'd0, slen, w, 3'(c),
                                                   pos + 4 >= n));
          end
        end
      end
      fkvs_pkg::KIND_DELETE: begin
        if (fkvs_pkg::key_reserved(key) || !tombstone(key))
          push_status(fkvs_pkg::ST_NOT_FOUND, 16'd0);
        else push_status(fkvs_pkg::ST_OK, 16'd0);
      end
      fkvs_pkg::KIND_ENUM_RESTART: begin
        walk_pos = fkvs_pkg::HDR_BYTES;
        push_status(fkvs_pkg::ST_OK, 16'd0);
      end
      fkvs_pkg::KIND_ENUM_NEXT: begin
        // Skip tombstones; the cursor may walk stale offsets after compaction.
        while (walk_pos < WALK_END && key_at(live_bank, walk_pos) == fkvs_pkg::KEY_DELETED)
          walk_pos += 16'(record_bytes(flash_rd(live_bank, walk_pos + 2)));
        if (walk_pos >= WALK_END || key_at(live_bank, walk_pos) == fkvs_pkg::KEY_FREE)
          push_status(fkvs_pkg::ST_END_OF_LIST, 16'd0);
        else begin
          key = key_at(live_bank, walk_pos);
          walk_pos += 16'(record_bytes(flash_rd(live_bank, walk_pos + 2)));
          push_status(fkvs_pkg::ST_OK, key);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial begin
    for (int i = 0; i < 2*BANK_BYTES; i++) flash_mem[i] = fkvs_pkg::BYTE_ERASED;
    write_magic(1'b0);
    live_bank    = 1'b0;
    put_key      = '0;
    put_len      = '0;
    put_cnt      = '0;
    for (int i = 0; i < 256; i++) put_bytes[i] = '0;
    walk_pos     = fkvs_pkg::HDR_BYTES;
    fail_count_o = 0;
  end

  always @(posedge clk_i) begin
    fkvs_pkg::res_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) apply_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = fkvs_pkg::mk_res(fkvs_pkg::status_e'(m_axis_tdata[2:0]), m_axis_tdata[18:3],
                               m_axis_tdata[26:19], m_axis_tdata[58:27],
                               m_axis_tdata[61:59], m_axis_tlast);
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h last %b", $time,
                   m_axis_tdata, m_axis_tlast);
          fail_count_o++;
        end else begin
          want = results_due.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("found_key", 32'(want.found_key), 32'(got.found_key));
          check_field("stored_length", 32'(want.stored_length), 32'(got.stored_length));
          check_field("data_word", want.data_word, got.data_word);
          check_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
          check_field("last_result", 32'(want.last_result), 32'(got.last_result));
        end
      end
    end
  end

  assign results_due_o = results_due.size();

endmodule

// ===== tb/flash_key_value_store_top_test.sv =====
// Testbench top for the flash key-value store: stimulus, receiver stalls and verdict.
module flash_key_value_store_top_test;

  localparam int          BANK_BYTES   = 1024;
  localparam int          CYCLE_LIMIT  = 10_000_000;
  localparam int          DRAIN_CYCLES = 5000;
  localparam int          ITEMS        = 180;
  localparam int          CALM_ITEMS   = 160;
  localparam logic [2:0]  KIND_SPARE_A = 3'd6;
  localparam logic [2:0]  KIND_SPARE_B = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          results_due;
  int          cycles;
  bit          calm;
  bit          hold_off_req;
  int          ops_sent;

  flash_key_value_store_top #(.BANK_BYTES(BANK_BYTES)) dut (.*);

  flash_key_value_store_checker #(.BANK_BYTES(BANK_BYTES)) checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .results_due_o(results_due)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request, none in the calm part.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end
    end
  end

  // Offer one transaction, optionally after a short gap; returns at the following falling edge.
  task automatic send_op(input logic [2:0] kind, input logic [15:0] key,
                         input logic [7:0] vlen, input logic [7:0] mlen,
                         input logic [31:0] word);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {word, mlen, vlen, key};
    do @(posedge clk_i); while (!s_axis_tready);
    ops_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_value(input logic [15:0] key, input logic [7:0] len,
                           input logic [31:0] seed, input bit scramble);
    send_op(fkvs_pkg::KIND_PUT_BEGIN, key, len, 8'($urandom), $urandom);
    for (int i = 0; i < (int'(len) + 3) / 4; i++)
      send_op(fkvs_pkg::KIND_PUT_DATA, 16'($urandom), 8'($urandom), 8'($urandom),
              scramble ? $urandom : seed + 32'(i));
  endtask

  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return fkvs_pkg::KEY_FREE;
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'($urandom_range(0, 16));
    if (r < 93) return 8'($urandom_range(17, 64));
    return 8'($urandom_range(65, 255));
  endfunction

  initial begin
    logic [2:0] kind;
    cycles        = 0;
    calm          = 1'b0;
    hold_off_req  = 1'b0;
    ops_sent      = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = fkvs_pkg::KIND_PUT_BEGIN;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part.
    put_value(16'h1234, 8'd5, 32'hA5A5_0F01, 1'b0);
    send_op(fkvs_pkg::KIND_GET, 16'h1234, 8'd0, 8'd255, 32'd0);
    send_op(fkvs_pkg::KIND_GET, 16'h1234, 8'd0, 8'd2, 32'd0);
    send_op(fkvs_pkg::KIND_GET, 16'h1234, 8'd0, 8'd0, 32'd0);
    put_value(16'h1234, 8'd5, 32'hA5A5_0F01, 1'b0);
    put_value(16'h1234, 8'd5, 32'h5A5A_F0FE, 1'b0);
    put_value(16'h8001, 8'd0, 32'd0, 1'b0);
    put_value(fkvs_pkg::KEY_DELETED, 8'd4, 32'hFFFF_FFFF, 1'b0);
    put_value(fkvs_pkg::KEY_FREE, 8'd0, 32'd0, 1'b0);
    send_op(fkvs_pkg::KIND_GET, fkvs_pkg::KEY_DELETED, 8'd0, 8'd9, 32'd0);
    send_op(fkvs_pkg::KIND_GET, fkvs_pkg::KEY_FREE, 8'd0, 8'd9, 32'd0);
    send_op(fkvs_pkg::KIND_DELETE, fkvs_pkg::KEY_DELETED, 8'd0, 8'd0, 32'd0);
    send_op(fkvs_pkg::KIND_DELETE, fkvs_pkg::KEY_FREE, 8'd0, 8'd0, 32'd0);
    send_op(fkvs_pkg::KIND_PUT_DATA, 16'h0, 8'd0, 8'd0, 32'hDEAD_BEEF);
    // Interleave a get inside a pending put; the last word carries surplus bytes.
    send_op(fkvs_pkg::KIND_PUT_BEGIN, 16'h00AA, 8'd6, 8'd0, 32'd0);
    send_op(fkvs_pkg::KIND_GET, 16'h1234, 8'd0, 8'd255, 32'd0);
    send_op(fkvs_pkg::KIND_PUT_DATA, 16'h0, 8'd0, 8'd0, 32'h0403_0201);
    send_op(fkvs_pkg::KIND_PUT_DATA, 16'h0, 8'd0, 8'd0, 32'hFFFF_0605);
    send_op(fkvs_pkg::KIND_ENUM_RESTART, 16'h0, 8'd0, 8'd0, 32'd0);
    repeat (4) send_op(fkvs_pkg::KIND_ENUM_NEXT, 16'h0, 8'd0, 8'd0, 32'd0);
    send_op(fkvs_pkg::KIND_DELETE, 16'h1234, 8'd0, 8'd0, 32'd0);
    send_op(fkvs_pkg::KIND_DELETE, 16'h1234, 8'd0, 8'd0, 32'd0);
    send_op(fkvs_pkg::KIND_GET, 16'h1234, 8'd0, 8'd255, 32'd0);
    send_op(KIND_SPARE_A, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_op(KIND_SPARE_B, 16'h0, 8'd0, 8'd0, 32'd0);
    put_value(16'hFFFE, 8'd255, 32'd0, 1'b1);
    send_op(fkvs_pkg::KIND_GET, 16'hFFFE, 8'd0, 8'd255, 32'd0);

    // Random part: mostly complete puts, gets and walks; some noise and broken puts.
    hold_off_req = 1'b1;
    while (ops_sent < ITEMS) begin
      if (ops_sent >= CALM_ITEMS) calm = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: put_value(pick_key(), pick_len(), $urandom, 1'b1);
        7, 8, 9, 10: begin
          send_op(fkvs_pkg::KIND_GET, pick_key(), 8'($urandom), 8'($urandom), $urandom);
        end
        11, 12: begin
          send_op(fkvs_pkg::KIND_DELETE, pick_key(), 8'($urandom), 8'($urandom), $urandom);
        end
        13: begin
          send_op(fkvs_pkg::KIND_ENUM_RESTART, 16'($urandom), 8'($urandom), 8'($urandom),
                  $urandom);
        end
        14, 15: begin
          send_op(fkvs_pkg::KIND_ENUM_NEXT, 16'($urandom), 8'($urandom), 8'($urandom),
                  $urandom);
        end
        16: begin
          // Broken put: abandoned after part of its data.
          send_op(fkvs_pkg::KIND_PUT_BEGIN, pick_key(), 8'($urandom_range(5, 40)),
                  8'($urandom), $urandom);
          send_op(fkvs_pkg::KIND_PUT_DATA, 16'($urandom), 8'($urandom), 8'($urandom),
                  $urandom);
        end
        17: send_op(fkvs_pkg::KIND_PUT_DATA, 16'($urandom), 8'($urandom), 8'($urandom),
                    $urandom);
        18: begin
          kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
          send_op(kind, 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
        end
        default: begin
          send_op(fkvs_pkg::KIND_GET, 16'($urandom_range(1, 12)), 8'($urandom), 8'd255,
                  $urandom);
        end
      endcase
    end

    s_axis_tvalid <= 1'b0;
    calm = 1'b1;
    while (results_due != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
